// ===== rtl/core/mm4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the 4x4 Q-format matrix multiply block.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM     = 4;
    localparam int IDX_W   = $clog2(DIM);
    localparam int ELEM_W  = 32;
    localparam int ROW_W   = DIM * ELEM_W;
    localparam int DATA_BITS = IDX_W + ROW_W;
    localparam int TDATA_W = ((DATA_BITS + 7) / 8) * 8;
    localparam int OP_W    = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // Operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_CUR  = 2'd0,
        OP_LOAD_OPND = 2'd1,
        OP_IDENTITY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOLD,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // One matrix row, element 0 in the lowest bits
    typedef logic [DIM-1:0][ELEM_W-1:0] t_row;

    // Step tags that travel beside the lane data
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_lane_ctl;

    // Width of a lane accumulator: four floored products plus growth
    function automatic int sum_width(input int frac_bits);
        return 2 * ELEM_W - frac_bits + 2;
    endfunction

endpackage

// ===== rtl/core/mm4_lane.sv =====
// ----------------------------------------------------------------------------
// mm4_lane
// One output column: registered operands, one 32x32 multiplier, floor shift
// and an accumulator over the four inner steps of a dot product.
// ----------------------------------------------------------------------------
module mm4_lane #(
    parameter int FRAC_BITS = 16,
    localparam int SUM_W = mm4_pkg::sum_width(FRAC_BITS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mm4_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [mm4_pkg::ELEM_W-1:0]   i_a,
    input  logic signed [mm4_pkg::ELEM_W-1:0]   i_b,
    output mm4_pkg::t_lane_ctl                  o_ctl,
    output logic signed [SUM_W-1:0]             o_sum
);
    import mm4_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;

    t_lane_ctl                  r_ctl1, r_ctl2, r_ctl3;
    logic signed [ELEM_W-1:0]   r_a, r_b;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SUM_W-1:0]    r_acc, n_acc;
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [SUM_W-1:0]    w_term;

    // Advance the step tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    // Floor the product to the fixed-point grid
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_term  = w_shift[SUM_W-1:0];

    // Restart on the first step, add on the others
    always_comb begin
        n_acc = r_acc;
        if (r_ctl2.vld) begin
            n_acc = r_ctl2.first ? w_term : r_acc + w_term;
        end
    end

    // Operand, product and accumulator registers
    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_b    <= i_b;
        r_prod <= PROD_W'(r_a) * PROD_W'(r_b);
        r_acc  <= n_acc;
    end

    assign o_ctl = r_ctl3;
    assign o_sum = r_acc;

endmodule

// ===== rtl/core/mm4_merge.sv =====
// ----------------------------------------------------------------------------
// mm4_merge
// Saturates the four lane sums into one product row and holds it in the
// output register until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module mm4_merge #(
    parameter int FRAC_BITS = 16,
    localparam int SUM_W = mm4_pkg::sum_width(FRAC_BITS)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_done,
    input  logic [mm4_pkg::IDX_W-1:0]               i_row,
    input  logic [mm4_pkg::DIM-1:0][SUM_W-1:0]      i_sum,
    input  logic                                    i_tready,
    output mm4_pkg::t_row                           o_row,
    output logic                                    o_tvalid,
    output logic [mm4_pkg::TDATA_W-1:0]             o_tdata,
    output logic                                    o_tlast
);
    import mm4_pkg::*;

    t_row                   w_sat;
    logic                   r_tvalid, n_tvalid;
    logic [TDATA_W-1:0]     r_tdata;
    logic                   r_tlast;

    // Clamp each column to 32 bits when the upper bits are not a sign copy
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            if ((&i_sum[j][SUM_W-1:ELEM_W-1]) || !(|i_sum[j][SUM_W-1:ELEM_W-1])) begin
                w_sat[j] = i_sum[j][ELEM_W-1:0];
            end else if (i_sum[j][SUM_W-1]) begin
                w_sat[j] = SAT_MIN;
            end else begin
                w_sat[j] = SAT_MAX;
            end
        end
    end

    // Load on a finished row, drop once taken
    always_comb begin
        n_tvalid = r_tvalid;
        if (i_done) begin
            n_tvalid = 1'b1;
        end else if (i_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else begin
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_done) begin
            r_tdata <= TDATA_W'({w_sat, i_row});
            r_tlast <= (i_row == LAST_IDX);
        end
    end

    assign o_row    = w_sat;
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

// ===== rtl/core/matrix4x4_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_accumulate
// 4x4 signed fixed-point matrix store with current = current * operand.
// ----------------------------------------------------------------------------
// Each input transaction carries one matrix row and an operation in tuser:
// load a row of the current matrix, load a row of the operand matrix, or
// reset the current matrix to identity; code 3 is taken and ignored. Loads
// and identity are accepted back to back. Loading operand row 3 starts a product:
// four column lanes, each with one multiplier, step through the inner index
// one element per cycle. Each product row first waits for a free output
// register, then issues its inner steps, which pass through the operand,
// product and accumulator registers of the lanes before the merged row
// loads the output register. A row is only started while the output
// register is free, so downstream stalls hold the product back. No input
// is accepted during a product. Each row is written back into the current
// matrix and sent out, with tlast on row 3.
// Operand rows must be loaded before they are used in a product.
module matrix4x4_multiply_accumulate #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_index[1:0], elem_0[33:2], elem_1[65:34], elem_2[97:66],
    // elem_3[129:98], zero fill above
    input  logic [mm4_pkg::TDATA_W-1:0]     s_axis_tdata,
    // operation[1:0]
    input  logic [mm4_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_row[1:0], out_0[33:2], out_1[65:34], out_2[97:66],
    // out_3[129:98], zero fill above
    output logic [mm4_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tlast
);
    import mm4_pkg::*;

    localparam int SUM_W = sum_width(FRAC_BITS);
    localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_i, r_k;
    t_row                   r_cur [DIM];
    t_row                   r_opnd [DIM];

    t_op                    w_op;
    logic [IDX_W-1:0]       w_row_index;
    t_row                   w_elems;
    logic                   w_accept;
    logic                   w_issue;
    logic                   w_done;
    t_lane_ctl              w_ctl;
    t_lane_ctl              w_lane_ctl;
    logic signed [ELEM_W-1:0] w_a;
    logic [DIM-1:0][SUM_W-1:0] w_sum;
    t_row                   w_prod_row;

    // Unpack the input transaction
    assign w_op        = t_op'(s_axis_tuser);
    assign w_row_index = s_axis_tdata[IDX_W-1:0];
    assign w_elems     = s_axis_tdata[IDX_W +: ROW_W];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_done      = w_lane_ctl.vld && w_lane_ctl.last;

    // Next state of the product sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_op == OP_LOAD_OPND && w_row_index == LAST_IDX) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_k == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_done) begin
                    n_state = (r_i == LAST_IDX) ? ST_IDLE : ST_HOLD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_issue       = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_ISSUE: w_issue = 1'b1;
            default: begin
                s_axis_tready = 1'b0;
                w_issue       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Row and inner-step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_k <= '0;
        end else begin
            if (r_state == ST_IDLE) begin
                r_i <= '0;
            end else if (r_state == ST_DRAIN && w_done) begin
                r_i <= r_i + IDX_W'(1);
            end
            if (w_issue) begin
                r_k <= r_k + IDX_W'(1);
            end else begin
                r_k <= '0;
            end
        end
    end

    // Current matrix: row loads, identity, product write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_cur[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (w_done) begin
            r_cur[r_i] <= w_prod_row;
        end else if (w_accept) begin
            case (w_op)
                OP_LOAD_CUR: r_cur[w_row_index] <= w_elems;
                OP_IDENTITY: begin
                    for (int r = 0; r < DIM; r++) begin
                        for (int c = 0; c < DIM; c++) begin
                            r_cur[r][c] <= (r == c) ? ONE : '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Operand matrix: row loads only
    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == OP_LOAD_OPND) begin
            r_opnd[w_row_index] <= w_elems;
        end
    end

    // Step tags and the shared left operand for all lanes
    assign w_ctl.vld   = w_issue;
    assign w_ctl.first = (r_k == '0);
    assign w_ctl.last  = (r_k == LAST_IDX);
    assign w_a         = r_cur[r_i][r_k];

    // One lane per output column
    for (genvar j = 0; j < DIM; j++) begin : g_lane
        logic signed [ELEM_W-1:0] w_b;
        logic signed [SUM_W-1:0]  w_lsum;

        assign w_b      = r_opnd[r_k][j];
        assign w_sum[j] = w_lsum;

        if (j == 0) begin : g_tag
            mm4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_a     (w_a),
                .i_b     (w_b),
                .o_ctl   (w_lane_ctl),
                .o_sum   (w_lsum)
            );
        end else begin : g_plain
            mm4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_a     (w_a),
                .i_b     (w_b),
                .o_ctl   (),
                .o_sum   (w_lsum)
            );
        end
    end

    // Merge the lane sums into a row and drive the output stream
    mm4_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_done   (w_done),
        .i_row    (r_i),
        .i_sum    (w_sum),
        .i_tready (m_axis_tready),
        .o_row    (w_prod_row),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/mm4_checker.sv =====
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks of the matrix multiply block, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [mm4_pkg::TDATA_W-1:0]     s_axis_tdata,
    input  logic [mm4_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [mm4_pkg::TDATA_W-1:0]     m_axis_tdata,
    input  logic                            m_axis_tlast
);
    import mm4_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // tlast marks exactly product row 3
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[IDX_W-1:0] == LAST_IDX)))
        else $error("tlast does not match the last product row");

    // Starting a product closes the input side
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD_OPND
        && s_axis_tdata[IDX_W-1:0] == LAST_IDX |=> !s_axis_tready)
        else $error("input accepted while a product starts");

    // Rows leave in order: a row after row r is row r+1, or row 0 after row 3
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        !m_axis_tvalid || m_axis_tdata[IDX_W-1:0] == $past(m_axis_tdata[IDX_W-1:0])
        + IDX_W'(1) || $past(m_axis_tdata[IDX_W-1:0]) == LAST_IDX)
        else $error("product rows out of order");

    // No input transaction is taken while a row is still being formed mid-product
    a_no_accept_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted inside a product");

endmodule

bind matrix4x4_multiply_accumulate mm4_checker u_mm4_checker (.*);

// ===== tb/matrix4x4_multiply_accumulate_tb.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_accumulate_tb
// Self-checking bench for the 4x4 fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
// Streams row transactions into the block: current-matrix row loads, operand
// row loads, identity requests and the unused code. A scoreboard keeps its
// own copy of both matrices, forms the product whenever operand row 3 lands
// and queues the four expected result rows. Every result transaction is
// compared field by field against the oldest queued row. A directed opening
// hits the element extremes, both saturation directions and negative
// truncation; random frames with random content follow, with random idling
// on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// One expected product row
typedef struct {
    logic [mm4_pkg::IDX_W-1:0] idx;
    mm4_pkg::t_row             vals;
    logic                      is_last;
} t_prod_row;

class mm4_scoreboard;
    int        frac;
    int        cur_m  [4][4];
    int        opnd_m [4][4];
    t_prod_row rows_q [$];
    int        errors;
    int        products;
    int        rows_checked;

    function new(int frac_bits);
        frac = frac_bits;
        errors = 0;
        products = 0;
        rows_checked = 0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                cur_m[i][j]  = (i == j) ? (1 << frac_bits) : 0;
                opnd_m[i][j] = 0;
            end
        end
    endfunction

    function int pending();
        return rows_q.size();
    endfunction

    // Print one mismatch line and count it
    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Update the matrices for one accepted input transaction
    function void note_input(logic [1:0] op, logic [1:0] idx, mm4_pkg::t_row vals);
        int        prod [4][4];
        longint    acc;
        t_prod_row r;
        if (op == mm4_pkg::OP_IDENTITY) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    cur_m[i][j] = (i == j) ? (1 << frac) : 0;
            return;
        end
        if (op != mm4_pkg::OP_LOAD_CUR && op != mm4_pkg::OP_LOAD_OPND)
            return;
        for (int j = 0; j < 4; j++) begin
            if (op == mm4_pkg::OP_LOAD_CUR)
                cur_m[idx][j] = vals[j];
            else
                opnd_m[idx][j] = vals[j];
        end
        if (op == mm4_pkg::OP_LOAD_CUR || idx != mm4_pkg::LAST_IDX)
            return;
        // Form current * operand: floored products, exact sum, saturate
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += (longint'(cur_m[i][k]) * longint'(opnd_m[k][j])) >>> frac;
                if (acc > 64'sd2147483647)
                    prod[i][j] = mm4_pkg::SAT_MAX;
                else if (acc < -64'sd2147483648)
                    prod[i][j] = mm4_pkg::SAT_MIN;
                else
                    prod[i][j] = int'(acc);
            end
        end
        cur_m = prod;
        products++;
        for (int i = 0; i < 4; i++) begin
            r.idx = i[1:0];
            for (int j = 0; j < 4; j++)
                r.vals[j] = prod[i][j];
            r.is_last = (i == 3);
            rows_q.push_back(r);
        end
    endfunction

    // Compare one result transaction with the oldest expected row
    task check_result(logic [1:0] idx, mm4_pkg::t_row vals, logic is_last);
        t_prod_row want;
        if (rows_q.size() == 0) begin
            report_mismatch("unexpected result row", {30'd0, idx}, 32'd0);
            return;
        end
        want = rows_q.pop_front();
        rows_checked++;
        if (idx !== want.idx)
            report_mismatch("out_row", {30'd0, idx}, {30'd0, want.idx});
        for (int j = 0; j < 4; j++)
            if (vals[j] !== want.vals[j])
                report_mismatch($sformatf("row %0d out_%0d", want.idx, j),
                                vals[j], want.vals[j]);
        if (is_last !== want.is_last)
            report_mismatch("last_row", {31'd0, is_last}, {31'd0, want.is_last});
    endtask
endclass

module matrix4x4_multiply_accumulate_tb;

    localparam int FRAC_BITS   = 16;
    localparam int ITEM_TARGET = 350;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 64;
    localparam logic [mm4_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // row_index[1:0], elem_0..elem_3 from bit 2 up, zero fill above
    logic [mm4_pkg::TDATA_W-1:0]  s_axis_tdata = '0;
    // operation[1:0]
    logic [mm4_pkg::OP_W-1:0]     s_axis_tuser = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // out_row[1:0], out_0..out_3 from bit 2 up, zero fill above
    logic [mm4_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                         m_axis_tlast;

    mm4_scoreboard sb;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  rx_hold_req = 1'b0;
    int  rx_hold_left = 0;

    matrix4x4_multiply_accumulate #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock: 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor both sides; results first, then the accepted input
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[mm4_pkg::IDX_W-1:0],
                                m_axis_tdata[mm4_pkg::IDX_W +: mm4_pkg::ROW_W],
                                m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[mm4_pkg::IDX_W-1:0],
                              s_axis_tdata[mm4_pkg::IDX_W +: mm4_pkg::ROW_W]);
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (m_axis_tvalid && m_axis_tready) ||
            (s_axis_tvalid && s_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("[matrix4x4_multiply_accumulate] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretch, and a long hold-off on request
    initial begin
        logic rdy;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rdy = 1'b0;
                rx_hold_left--;
            end else if (quiet) begin
                rdy = 1'b1;
            end else begin
                rdy = ($urandom_range(0, 99) >= 11);
            end
            m_axis_tready <= rdy;
        end
    end

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3, 4, 5: return $urandom;
            // small magnitudes, within +-4.0
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic mm4_pkg::t_row rand_row();
        mm4_pkg::t_row r;
        for (int j = 0; j < 4; j++)
            r[j] = rand_elem();
        return r;
    endfunction

    function automatic mm4_pkg::t_row fill_row(logic [31:0] v);
        return {v, v, v, v};
    endfunction

    // Offer one row transaction and hold it until accepted
    task automatic send_item(logic [1:0] op, logic [1:0] idx, mm4_pkg::t_row vals);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= mm4_pkg::TDATA_W'({vals, idx});
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Well-formed frame: optional identity, current rows, operand rows, row 3
    task automatic send_frame();
        int n_cur;
        n_cur = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            send_item(mm4_pkg::OP_IDENTITY, 2'($urandom_range(0, 3)), rand_row());
        for (int n = 0; n < n_cur; n++)
            send_item(mm4_pkg::OP_LOAD_CUR, 2'($urandom_range(0, 3)), rand_row());
        for (int r = 0; r < 3; r++)
            if ($urandom_range(0, 3) != 0)
                send_item(mm4_pkg::OP_LOAD_OPND, 2'(r), rand_row());
        send_item(mm4_pkg::OP_LOAD_OPND, mm4_pkg::LAST_IDX, rand_row());
    endtask

    initial begin
        bit held;
        bit drained;
        held = 1'b0;
        drained = 1'b0;
        sb = new(FRAC_BITS);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored code, identity with junk, identity * operand
        send_item(OP_UNUSED, 2'd3, rand_row());
        send_item(mm4_pkg::OP_IDENTITY, 2'd3, fill_row(32'hFFFF_FFFF));
        for (int r = 0; r < 3; r++)
            send_item(mm4_pkg::OP_LOAD_OPND, 2'(r), rand_row());
        send_item(mm4_pkg::OP_LOAD_OPND, mm4_pkg::LAST_IDX,
                  {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_8000, 32'h0001_4000});
        // Largest positive everywhere: saturate high
        for (int r = 0; r < 4; r++)
            send_item(mm4_pkg::OP_LOAD_CUR, 2'(r), fill_row(32'h7FFF_FFFF));
        for (int r = 0; r < 4; r++)
            send_item(mm4_pkg::OP_LOAD_OPND, 2'(r), fill_row(32'h7FFF_FFFF));
        // Most negative current times largest operand: saturate low
        for (int r = 0; r < 4; r++)
            send_item(mm4_pkg::OP_LOAD_CUR, 2'(r), fill_row(32'h8000_0000));
        send_item(mm4_pkg::OP_LOAD_OPND, mm4_pkg::LAST_IDX, fill_row(32'h7FFF_FFFF));
        // Tiny negative terms: truncation toward minus infinity
        send_item(mm4_pkg::OP_IDENTITY, 2'd0, fill_row(32'h0000_0000));
        send_item(mm4_pkg::OP_LOAD_CUR, 2'd1,
                  {32'h0001_8000, 32'hFFFF_FFFD, 32'h0000_0001, 32'hFFFF_FFFF});
        send_item(mm4_pkg::OP_LOAD_OPND, mm4_pkg::LAST_IDX,
                  {32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0003, 32'hFFFF_0001});
        send_item(OP_UNUSED, 2'd0, fill_row(32'h0000_0000));

        // Random: mostly frames, some loose transactions
        while (items_sent < ITEM_TARGET) begin
            quiet = (items_sent >= 160 && items_sent < 220);
            if (!held && items_sent >= 120) begin
                // hold the output off while input keeps coming
                held = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (!drained && items_sent >= 250) begin
                // pause input until every expected row has come out
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            if ($urandom_range(0, 99) < 75)
                send_frame();
            else
                send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_row());
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        // Drain, then allow for one product's worth of stray output
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d row transactions, %0d products formed, %0d result rows checked",
                 items_sent, sb.products, sb.rows_checked);
        $display("Included saturation both ways, identity, ignored code, hold-off and drain");
        if (sb.errors == 0) begin
            $display("[matrix4x4_multiply_accumulate] OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("[matrix4x4_multiply_accumulate] ERROR");
        end
        $finish;
    end

endmodule
